// ===== hdl/moving_average_filter_core_assert.svh =====
`ifndef MOVING_AVERAGE_FILTER_CORE_ASSERT_SVH
`define MOVING_AVERAGE_FILTER_CORE_ASSERT_SVH

// Same-cycle check: when ante holds, cons must hold on the same edge.
`define MAF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle check: when ante holds, cons must hold on the following edge.
`define MAF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/maf_pkg.sv =====
`default_nettype none

package maf_pkg;

   localparam int SAMPLE_W       = 16;
   localparam int LEN_W          = 8;
   localparam int SUM_W          = 24;
   localparam int WIN_RESET      = 8;
   localparam int MAX_WINDOW_DEF = 256;

   typedef enum logic {
      CMD_FILTER = 1'b0,
      CMD_CLEAR  = 1'b1
   } cmd_type;

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] dividend;
      logic [LEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [SUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== hdl/maf_ram.sv =====
`default_nettype none

module maf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== hdl/maf_div.sv =====
`default_nettype none

module maf_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire maf_pkg::div_req_type div_req,
   output maf_pkg::div_rsp_type      div_rsp
);

   import maf_pkg::*;

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [LEN_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [LEN_W:0]   trial;
   logic [LEN_W:0]   diff;
   logic             ge;

   // One restoring step per cycle, quotient bits shift in from the right.
   always_comb begin
      trial   = {rem_ff, quo_ff[SUM_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      ge      = (trial >= {1'b0, dvs_ff});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = CNT_W'(SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

// ===== hdl/moving_average_filter_core.sv =====
// Boxcar moving average core: one item at a time, req_ready high only when idle.
// Primed sample: accepted in IDLE, then S_READ, S_DIVST, S_DIV and S_PUSH; the
// 24-step serial divider (one quotient bit per cycle) runs in S_DIV.
// First sample after reset or clear: S_FILL writes it to every window slot,
// one ring write a cycle, then S_PUSH. Clear item: no result.
// Synchronous active-high reset clears sum, position, primed flag, window to 8.
`default_nettype none

`include "moving_average_filter_core_assert.svh"

module moving_average_filter_core #(
   parameter int MAX_WINDOW = maf_pkg::MAX_WINDOW_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_command,
   input  wire logic [maf_pkg::SAMPLE_W-1:0] req_sample,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic      [maf_pkg::SAMPLE_W-1:0] rsp_average,
   input  wire logic                         csr_wr_en,
   input  wire logic [maf_pkg::LEN_W-1:0]    csr_wr_data
);

   import maf_pkg::*;

   localparam int ADDR_W = $clog2(MAX_WINDOW);

   // Cap for the effective window, one bit wider so a full 256 still fits.
   localparam logic [LEN_W:0] MAX_WIN = (LEN_W + 1)'(MAX_WINDOW);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FILL  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_DIVST = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_PUSH  = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [LEN_W-1:0]    win_ff, win_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [LEN_W-1:0]    pos_ff, pos_in;
   logic                primed_ff, primed_in;
   logic [LEN_W-1:0]    fill_ff, fill_in;
   logic [SAMPLE_W-1:0] smp_ff, smp_in;
   logic [SAMPLE_W-1:0] res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_avg_ff, rsp_avg_in;

   logic [LEN_W-1:0]    len;
   logic [LEN_W-1:0]    pos_eff;
   logic [LEN_W:0]      pos_nxt;
   logic                req_acc;
   logic                out_free;

   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [SAMPLE_W-1:0] ram_rdata;

   div_req_type         div_req;
   div_rsp_type         div_rsp;

   // Effective window: zero acts as one, anything above the ring depth saturates.
   always_comb begin
      len = win_ff;
      if (win_ff == '0) begin
         len = LEN_W'(1);
      end else if ({1'b0, win_ff} > MAX_WIN) begin
         len = MAX_WIN[LEN_W-1:0];
      end
   end

   // Wrap a stale position left over from a shrunk window before use.
   assign pos_eff  = (pos_ff >= len) ? '0 : pos_ff;
   assign pos_nxt  = {1'b0, pos_ff} + 1'b1;
   assign req_ready = (state_ff == S_IDLE);
   assign req_acc  = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign win_in = csr_wr_en ? csr_wr_data : win_ff;

   // Ring writes: the fill sweep uses its own counter, the update reuses the
   // slot read in the accept cycle.
   assign ram_we    = (state_ff == S_FILL) || (state_ff == S_READ);
   assign ram_waddr = (state_ff == S_FILL) ? fill_ff[ADDR_W-1:0] : pos_ff[ADDR_W-1:0];

   assign div_req.start    = (state_ff == S_DIVST);
   assign div_req.dividend = sum_ff;
   assign div_req.divisor  = len;

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      pos_in       = pos_ff;
      primed_in    = primed_ff;
      fill_in      = fill_ff;
      smp_in       = smp_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_avg_in   = rsp_avg_ff;

      // Drop the held result once the consumer takes it.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               smp_in = req_sample;
               if (req_command == CMD_CLEAR) begin
                  sum_in    = '0;
                  pos_in    = '0;
                  primed_in = 1'b0;
               end else if (!primed_ff) begin
                  // First sample: the whole window holds it, result is the sample.
                  sum_in   = SUM_W'(req_sample) * SUM_W'(len);
                  res_in   = req_sample;
                  fill_in  = '0;
                  state_in = S_FILL;
               end else begin
                  // Ring read of the oldest slot is in flight this cycle.
                  pos_in   = pos_eff;
                  state_in = S_READ;
               end
            end
         end
         S_FILL: begin
            fill_in = fill_ff + 1'b1;
            if (fill_ff == len - 1'b1) begin
               pos_in    = '0;
               primed_in = 1'b1;
               state_in  = S_PUSH;
            end
         end
         S_READ: begin
            // Retire the oldest sample and add the new one, both mod 2^24.
            sum_in   = sum_ff - SUM_W'(ram_rdata) + SUM_W'(smp_ff);
            pos_in   = (pos_nxt >= {1'b0, len}) ? '0 : pos_nxt[LEN_W-1:0];
            state_in = S_DIVST;
         end
         S_DIVST: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               // Saturate: a quotient past 16 bits only follows a window change.
               res_in   = (div_rsp.quotient[SUM_W-1:SAMPLE_W] != '0) ?
                          '1 : div_rsp.quotient[SAMPLE_W-1:0];
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            // Hold until the output register is free.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_avg_in   = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         win_ff       <= LEN_W'(WIN_RESET);
         sum_ff       <= '0;
         pos_ff       <= '0;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_ff       <= win_in;
         sum_ff       <= sum_in;
         pos_ff       <= pos_in;
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fill_ff    <= fill_in;
      smp_ff     <= smp_in;
      res_ff     <= res_in;
      rsp_avg_ff <= rsp_avg_in;
   end

   maf_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(MAX_WINDOW)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(smp_ff),
      .rd_addr(pos_eff[ADDR_W-1:0]),
      .rd_data(ram_rdata)
   );

   maf_div u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_avg_ff;

   `MAF_ASSERT_NOW(a_div_start_idle, clock, reset, div_req.start, !div_rsp.busy,
      "divider started while busy")

   `MAF_ASSERT_NEXT(a_clear_state, clock, reset,
      req_valid && req_ready && (req_command == CMD_CLEAR),
      !primed_ff && (sum_ff == '0) && (pos_ff == '0),
      "clear did not reset filter state")

   `MAF_ASSERT_NOW(a_pos_in_window, clock, reset, state_ff == S_READ, pos_ff < len,
      "ring position outside window during update")

   `MAF_ASSERT_NEXT(a_first_sample_fill, clock, reset,
      req_valid && req_ready && (req_command == CMD_FILTER) && !primed_ff,
      state_ff == S_FILL,
      "first sample did not start the window fill")

endmodule

`default_nettype wire
